@@ hdl/owbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

    localparam int CFG_WIDTH     = 10;
    localparam int CFG_COUNT     = 8;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESET_REC     = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRES_WAIT     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PRES_LOW      = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WR_ONE_LOW    = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WR_ONE_HIGH   = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WR_ZERO_LOW   = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WR_ZERO_HIGH  = 3'd7;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET_VALS [CFG_COUNT] = '{
        10'd500, 10'd15, 10'd100, 10'd240, 10'd8, 10'd60, 10'd70, 10'd2
    };

    localparam logic [CFG_WIDTH-1:0] RD_LOW_TICKS  = 10'd6;
    localparam logic [CFG_WIDTH-1:0] RD_REL_TICKS  = 10'd2;
    localparam logic [CFG_WIDTH-1:0] RD_WAIT_TICKS = 10'd8;

    typedef struct packed {
        logic       is_tick;
        logic       is_reset;
        logic       is_write;
        logic       is_read;
        logic [7:0] tx_byte;
        logic       line_level;
    } op_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_presence;
        logic [7:0] rx_byte;
        logic       command_dropped;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/owbm_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module owbm_fifo
    import owbm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/owbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module owbm_front
    import owbm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] action,
    input  wire logic [7:0] tx_byte,
    input  wire logic       line_level,
    input  wire logic       op_pop,
    output op_t             op,
    output logic            op_empty
);

    op_t cls;

    // decode the action into one flag per kind of word
    always_comb
    begin
        cls            = '0;
        cls.tx_byte    = tx_byte;
        cls.line_level = line_level;
        unique case (action)
            ACT_TICK:  cls.is_tick  = 1'b1;
            ACT_RESET: cls.is_reset = 1'b1;
            ACT_WRITE: cls.is_write = 1'b1;
            ACT_READ:  cls.is_read  = 1'b1;
            default:   cls.is_tick  = 1'b1;
        endcase
    end

    owbm_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (DEPTH)
    ) u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (op_pop),
        .rdata (op),
        .empty (op_empty)
    );

endmodule

`default_nettype wire

@@ hdl/owbm_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module owbm_exec
    import owbm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]     cfg_data,
    input  wire op_t                      op,
    input  wire logic                     op_empty,
    output logic                          op_pop,
    output res_t                          res,
    output logic                          res_push,
    input  wire logic                     res_full
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REC   = 4'd2;
    localparam logic [3:0] PH_PRES_WAIT = 4'd3;
    localparam logic [3:0] PH_PRES_LOW  = 4'd4;
    localparam logic [3:0] PH_WR_LOW    = 4'd5;
    localparam logic [3:0] PH_WR_HIGH   = 4'd6;
    localparam logic [3:0] PH_RD_LOW    = 4'd7;
    localparam logic [3:0] PH_RD_REL    = 4'd8;
    localparam logic [3:0] PH_RD_WAIT   = 4'd9;

    logic [CFG_WIDTH-1:0] cfg_reg [CFG_COUNT];

    logic [3:0]           phase_reg;
    logic [3:0]           phase_next;
    logic [CFG_WIDTH-1:0] tick_reg;
    logic [CFG_WIDTH-1:0] tick_next;
    logic [2:0]           bit_reg;
    logic [2:0]           bit_next;
    logic [7:0]           shift_reg;
    logic [7:0]           shift_next;
    logic                 fail_reg;
    logic                 fail_next;
    logic [7:0]           rx_reg;
    logic [7:0]           rx_next;

    logic                 fire;
    logic [CFG_WIDTH-1:0] base;
    logic [CFG_WIDTH-1:0] inc;
    logic [CFG_WIDTH-1:0] len;
    logic                 hit;
    logic [CFG_WIDTH-1:0] tick_adv;
    logic [7:0]           shift_rd;
    logic                 done;
    logic                 dropped;

    assign fire     = !op_empty && !res_full;
    assign op_pop   = fire;
    assign res_push = fire;

    // phase length of the current tick
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:   len = cfg_reg[REG_RESET_LOW];
            PH_RST_REC:   len = cfg_reg[REG_RESET_REC];
            PH_PRES_WAIT: len = op.line_level ? cfg_reg[REG_PRES_WAIT] : cfg_reg[REG_PRES_LOW];
            PH_PRES_LOW:  len = cfg_reg[REG_PRES_LOW];
            PH_WR_LOW:    len = shift_reg[0] ? cfg_reg[REG_WR_ONE_LOW]
                                             : cfg_reg[REG_WR_ZERO_LOW];
            PH_WR_HIGH:   len = shift_reg[0] ? cfg_reg[REG_WR_ONE_HIGH]
                                             : cfg_reg[REG_WR_ZERO_HIGH];
            PH_RD_LOW:    len = RD_LOW_TICKS;
            PH_RD_REL:    len = RD_REL_TICKS;
            PH_RD_WAIT:   len = RD_WAIT_TICKS;
            default:      len = '0;
        endcase
    end

    // pulse count restarts at the first low tick of the presence wait
    assign base     = (phase_reg == PH_PRES_WAIT && !op.line_level) ? '0 : tick_reg;
    assign inc      = base + 1'b1;
    assign hit      = (inc >= len);
    assign tick_adv = hit ? '0 : inc;
    assign shift_rd = (tick_reg == '0) ? {op.line_level, shift_reg[7:1]} : shift_reg;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        dropped    = 1'b0;
        if (op.is_tick)
        begin
            unique case (phase_reg)
                PH_RST_LOW:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        phase_next = PH_RST_REC;
                    end
                end
                PH_RST_REC:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        phase_next = PH_PRES_WAIT;
                    end
                end
                PH_PRES_WAIT:
                begin
                    tick_next = tick_adv;
                    if (!op.line_level)
                    begin
                        phase_next = PH_PRES_LOW;
                    end
                    if (hit)
                    begin
                        fail_next  = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_PRES_LOW:
                begin
                    if (op.line_level)
                    begin
                        tick_next  = '0;
                        fail_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_adv;
                        if (hit)
                        begin
                            fail_next  = 1'b1;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                PH_WR_LOW:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        phase_next = PH_WR_HIGH;
                    end
                end
                PH_WR_HIGH:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        if (bit_reg == 3'd7)
                        begin
                            bit_next   = '0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_WR_LOW;
                        end
                    end
                end
                PH_RD_LOW:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        phase_next = PH_RD_REL;
                    end
                end
                PH_RD_REL:
                begin
                    tick_next = tick_adv;
                    if (hit)
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                end
                PH_RD_WAIT:
                begin
                    tick_next  = tick_adv;
                    shift_next = shift_rd;
                    if (hit)
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            bit_next   = '0;
                            rx_next    = shift_rd;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_RD_LOW;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (phase_reg != PH_IDLE)
        begin
            dropped = 1'b1;
        end
        else
        begin
            tick_next = '0;
            bit_next  = '0;
            priority if (op.is_reset)
            begin
                phase_next = PH_RST_LOW;
            end
            else if (op.is_write)
            begin
                shift_next = op.tx_byte;
                phase_next = PH_WR_LOW;
            end
            else
            begin
                shift_next = '0;
                phase_next = PH_RD_LOW;
            end
        end
    end

    always_comb
    begin
        res.drive_low       = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                              || (phase_next == PH_RD_LOW);
        res.busy_res        = (phase_next != PH_IDLE);
        res.done_res        = done;
        res.no_presence     = fail_next;
        res.rx_byte         = rx_next;
        res.command_dropped = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            fail_reg  <= 1'b0;
            rx_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            fail_reg  <= fail_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET_VALS;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/one_wire_bus_master_unit.sv @@
// channel   direction   handshake        payload
// input     in          push / full      action, tx_byte, line_level
// result    out         pop / empty      drive_low, busy_res, done_res, no_presence,
//                                        rx_byte, command_dropped
// config    in          cfg_wr_en        cfg_index, cfg_data
//
// one word per cycle in and out, and one through the execute stage, while no queue stalls
// a word goes through the input queue and the execute stage into the result queue
// each queue holds QUEUE_DEPTH_P words; a short stall on one side does not stop the other
// reset is asynchronous; registers return to their defaults, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master_unit
    import owbm_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [1:0]               action,
    input  wire logic [7:0]               tx_byte,
    input  wire logic                     line_level,
    input  wire logic                     pop,
    output logic                          empty,
    output logic                          drive_low,
    output logic                          busy_res,
    output logic                          done_res,
    output logic                          no_presence,
    output logic [7:0]                    rx_byte,
    output logic                          command_dropped,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

    op_t  op;
    logic op_empty;
    logic op_pop;
    res_t res_in;
    logic res_push;
    logic res_full;
    res_t res_out;

    owbm_front #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .tx_byte    (tx_byte),
        .line_level (line_level),
        .op_pop     (op_pop),
        .op         (op),
        .op_empty   (op_empty)
    );

    owbm_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .res       (res_in),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    owbm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH_P)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign drive_low       = res_out.drive_low;
    assign busy_res        = res_out.busy_res;
    assign done_res        = res_out.done_res;
    assign no_presence     = res_out.no_presence;
    assign rx_byte         = res_out.rx_byte;
    assign command_dropped = res_out.command_dropped;

endmodule

`default_nettype wire

@@ hdl/owbm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module owbm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic       drive_low,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic       no_presence,
    input wire logic [7:0] rx_byte,
    input wire logic       command_dropped
);

    // a finishing word leaves the line released and the unit free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> (!busy_res && !drive_low))
        else $error("done word still busy or driving");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && drive_low) |-> busy_res)
        else $error("line driven while idle");

    // a dropped command leaves the running command untouched
    a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && command_dropped) |-> (busy_res && !done_res))
        else $error("dropped command with idle or finishing state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rx_byte) && $stable(no_presence)))
        else $error("waiting result word changed");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import owbm_pkg::*;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_PULSE,
        SEQ_RST_RECOVER,
        SEQ_PRES_WAIT,
        SEQ_PRES_PULSE,
        SEQ_WR_PULSE,
        SEQ_WR_REST,
        SEQ_RD_PULSE,
        SEQ_RD_RELEASE,
        SEQ_RD_SETTLE
    } bus_seq_e;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
        logic       lvl;
    } bus_item_t;

    localparam logic [9:0] READ_PULSE_LEN   = 10'd6;
    localparam logic [9:0] READ_RELEASE_LEN = 10'd2;
    localparam logic [9:0] READ_SETTLE_LEN  = 10'd8;
    localparam int         SLOT_TICKS       = 16;
    localparam int         RANDOM_LEVEL     = 2;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [1:0]               action = ACT_TICK;
    logic [7:0]               tx_byte = 8'h00;
    logic                     line_level = 1'b0;
    logic                     pop = 1'b0;
    logic                     empty;
    logic                     drive_low;
    logic                     busy_res;
    logic                     done_res;
    logic                     no_presence;
    logic [7:0]               rx_byte;
    logic                     command_dropped;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]     cfg_data = '0;

    one_wire_bus_master_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .tx_byte         (tx_byte),
        .line_level      (line_level),
        .pop             (pop),
        .empty           (empty),
        .drive_low       (drive_low),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .no_presence     (no_presence),
        .rx_byte         (rx_byte),
        .command_dropped (command_dropped),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 clk = ~clk;

    // bus master shadow
    bus_seq_e   bus_seq = SEQ_IDLE;
    logic [9:0] tick_cnt = '0;
    logic [2:0] bit_pos = '0;
    logic [7:0] shift_reg = '0;
    logic       pres_fail = 1'b0;
    logic [7:0] rx_last = '0;
    logic [9:0] reg_shadow [CFG_COUNT] = '{10'd500, 10'd15, 10'd100, 10'd240,
                                           10'd8, 10'd60, 10'd70, 10'd2};

    bus_item_t pending_items [$];
    res_t      due_responses [$];
    int        items_queued = 0;
    int        responses_seen = 0;
    int        err_count = 0;
    bit        gaps_on = 1'b1;
    int        send_hold = 0;
    int        take_hold = 0;
    bus_item_t next_item;
    res_t      want;

    function automatic logic count_up(input logic [9:0] len);
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= len)
        begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic advance_tick(input logic lvl);
        case (bus_seq)
            SEQ_RST_PULSE:
                if (count_up(reg_shadow[REG_RESET_LOW])) bus_seq = SEQ_RST_RECOVER;
            SEQ_RST_RECOVER:
                if (count_up(reg_shadow[REG_RESET_REC])) bus_seq = SEQ_PRES_WAIT;
            SEQ_PRES_WAIT:
            begin
                if (lvl)
                begin
                    if (count_up(reg_shadow[REG_PRES_WAIT]))
                    begin
                        pres_fail = 1'b1;
                        bus_seq = SEQ_IDLE;
                        return 1'b1;
                    end
                end
                else
                begin
                    tick_cnt = '0;
                    bus_seq = SEQ_PRES_PULSE;
                    if (count_up(reg_shadow[REG_PRES_LOW]))
                    begin
                        pres_fail = 1'b1;
                        bus_seq = SEQ_IDLE;
                        return 1'b1;
                    end
                end
            end
            SEQ_PRES_PULSE:
            begin
                if (lvl)
                begin
                    tick_cnt = '0;
                    pres_fail = 1'b0;
                    bus_seq = SEQ_IDLE;
                    return 1'b1;
                end
                if (count_up(reg_shadow[REG_PRES_LOW]))
                begin
                    pres_fail = 1'b1;
                    bus_seq = SEQ_IDLE;
                    return 1'b1;
                end
            end
            SEQ_WR_PULSE:
                if (count_up(shift_reg[0] ? reg_shadow[REG_WR_ONE_LOW]
                                          : reg_shadow[REG_WR_ZERO_LOW]))
                    bus_seq = SEQ_WR_REST;
            SEQ_WR_REST:
            begin
                if (count_up(shift_reg[0] ? reg_shadow[REG_WR_ONE_HIGH]
                                          : reg_shadow[REG_WR_ZERO_HIGH]))
                begin
                    shift_reg = shift_reg >> 1;
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        bus_seq = SEQ_IDLE;
                        return 1'b1;
                    end
                    bit_pos = bit_pos + 3'd1;
                    bus_seq = SEQ_WR_PULSE;
                end
            end
            SEQ_RD_PULSE:
                if (count_up(READ_PULSE_LEN)) bus_seq = SEQ_RD_RELEASE;
            SEQ_RD_RELEASE:
                if (count_up(READ_RELEASE_LEN)) bus_seq = SEQ_RD_SETTLE;
            SEQ_RD_SETTLE:
            begin
                if (tick_cnt == '0)
                    shift_reg = {lvl, shift_reg[7:1]};
                if (count_up(READ_SETTLE_LEN))
                begin
                    if (bit_pos == 3'd7)
                    begin
                        bit_pos = '0;
                        rx_last = shift_reg;
                        bus_seq = SEQ_IDLE;
                        return 1'b1;
                    end
                    bit_pos = bit_pos + 3'd1;
                    bus_seq = SEQ_RD_PULSE;
                end
            end
            default:
                bus_seq = SEQ_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic res_t master_response(input logic [1:0] act, input logic [7:0] data,
                                             input logic lvl);
        res_t r;
        logic fin;
        logic dropped;
        fin = 1'b0;
        dropped = 1'b0;
        if (act == ACT_TICK)
            fin = advance_tick(lvl);
        else if (bus_seq != SEQ_IDLE)
            dropped = 1'b1;
        else
        begin
            tick_cnt = '0;
            bit_pos = '0;
            if (act == ACT_RESET)
                bus_seq = SEQ_RST_PULSE;
            else if (act == ACT_WRITE)
            begin
                shift_reg = data;
                bus_seq = SEQ_WR_PULSE;
            end
            else
            begin
                shift_reg = '0;
                bus_seq = SEQ_RD_PULSE;
            end
        end
        r.drive_low = (bus_seq == SEQ_RST_PULSE) || (bus_seq == SEQ_WR_PULSE)
                      || (bus_seq == SEQ_RD_PULSE);
        r.busy_res = (bus_seq != SEQ_IDLE);
        r.done_res = fin;
        r.no_presence = pres_fail;
        r.rx_byte = rx_last;
        r.command_dropped = dropped;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!(push && full))
        begin
            if (push)
                due_responses.push_back(master_response(action, tx_byte, line_level));
            if (send_hold > 0)
            begin
                send_hold--;
                push <= 1'b0;
            end
            else if (pending_items.size() > 0 && gaps_on && $urandom_range(0, 11) == 0)
            begin
                send_hold = $urandom_range(0, 4);
                push <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                action <= next_item.act;
                tx_byte <= next_item.data;
                line_level <= next_item.lvl;
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                responses_seen++;
                if (due_responses.size() == 0)
                    flag_mismatch("result word with nothing expected");
                else
                begin
                    want = due_responses.pop_front();
                    if (drive_low !== want.drive_low)
                        flag_mismatch($sformatf("word %0d drive_low %b, want %b",
                                                responses_seen, drive_low, want.drive_low));
                    if (busy_res !== want.busy_res)
                        flag_mismatch($sformatf("word %0d busy_res %b, want %b",
                                                responses_seen, busy_res, want.busy_res));
                    if (done_res !== want.done_res)
                        flag_mismatch($sformatf("word %0d done_res %b, want %b",
                                                responses_seen, done_res, want.done_res));
                    if (no_presence !== want.no_presence)
                        flag_mismatch($sformatf("word %0d no_presence %b, want %b",
                                                responses_seen, no_presence, want.no_presence));
                    if (rx_byte !== want.rx_byte)
                        flag_mismatch($sformatf("word %0d rx_byte %h, want %h",
                                                responses_seen, rx_byte, want.rx_byte));
                    if (command_dropped !== want.command_dropped)
                        flag_mismatch($sformatf("word %0d command_dropped %b, want %b",
                                                responses_seen, command_dropped,
                                                want.command_dropped));
                end
            end
            if (take_hold > 0)
            begin
                take_hold--;
                pop <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                take_hold = $urandom_range(0, 4);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic int eff_len(input logic [9:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    task automatic add_item(input logic [1:0] act, input logic [7:0] data, input logic lvl);
        bus_item_t it;
        it.act = act;
        it.data = data;
        it.lvl = lvl;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic add_ticks(input int n, input int lvl);
        for (int i = 0; i < n; i++)
            add_item(ACT_TICK, 8'($urandom_range(0, 255)),
                     (lvl == RANDOM_LEVEL) ? 1'($urandom_range(0, 1)) : lvl[0]);
    endtask

    // command while busy, dropped without using a tick
    task automatic maybe_stray();
        if ($urandom_range(0, 5) == 0)
            add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    // style 0 presence found, 1 no pulse, 2 pulse too long, else noise
    task automatic gen_reset(input int style);
        int wl;
        int ll;
        int hi_n;
        wl = eff_len(reg_shadow[REG_PRES_WAIT]);
        ll = eff_len(reg_shadow[REG_PRES_LOW]);
        add_item(ACT_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        maybe_stray();
        add_ticks(eff_len(reg_shadow[REG_RESET_LOW]) + eff_len(reg_shadow[REG_RESET_REC]),
                  RANDOM_LEVEL);
        hi_n = $urandom_range(0, wl - 1);
        case (style)
            0:
            begin
                add_ticks(hi_n, 1);
                add_ticks((ll > 1) ? $urandom_range(1, ll - 1) : 1, 0);
                add_ticks(1, 1);
            end
            1: add_ticks(wl, 1);
            2:
            begin
                add_ticks(hi_n, 1);
                add_ticks(ll, 0);
            end
            default: add_ticks($urandom_range(0, wl + ll), RANDOM_LEVEL);
        endcase
    endtask

    task automatic gen_write(input logic [7:0] b);
        int n;
        n = 0;
        add_item(ACT_WRITE, b, 1'($urandom_range(0, 1)));
        maybe_stray();
        for (int i = 0; i < 8; i++)
            n += b[i]
                 ? eff_len(reg_shadow[REG_WR_ONE_LOW]) + eff_len(reg_shadow[REG_WR_ONE_HIGH])
                 : eff_len(reg_shadow[REG_WR_ZERO_LOW]) + eff_len(reg_shadow[REG_WR_ZERO_HIGH]);
        add_ticks(n, RANDOM_LEVEL);
    endtask

    task automatic gen_read(input int lvl);
        add_item(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        maybe_stray();
        add_ticks(8 * SLOT_TICKS, lvl);
    endtask

    task automatic gen_mix(input int budget);
        int start;
        int pick;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                gen_reset($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : 3);
            else if (pick < 60)
                gen_write(8'($urandom_range(0, 255)));
            else if (pick < 85)
                gen_read(RANDOM_LEVEL);
            else
                repeat ($urandom_range(1, 4))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            add_ticks($urandom_range(0, 2), RANDOM_LEVEL);
        end
    endtask

    task automatic drain();
        while (responses_seen != items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input int val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[CFG_IDX_WIDTH-1:0];
        cfg_data <= val[CFG_WIDTH-1:0];
        reg_shadow[idx] = val[CFG_WIDTH-1:0];
    endtask

    task automatic set_all(input int v0, input int v1, input int v2, input int v3,
                           input int v4, input int v5, input int v6, input int v7);
        int v [CFG_COUNT];
        v = '{v0, v1, v2, v3, v4, v5, v6, v7};
        for (int i = 0; i < CFG_COUNT; i++)
            write_reg(i, v[i]);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_random(input int hi);
        set_all($urandom_range(0, hi), $urandom_range(1, hi), $urandom_range(1, hi),
                $urandom_range(1, hi), $urandom_range(1, hi), $urandom_range(0, hi),
                $urandom_range(1, hi), $urandom_range(1, hi));
    endtask

    initial
    begin
        int spins;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults, quick presence pulse
        add_ticks(2, RANDOM_LEVEL);
        add_item(ACT_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_ticks(eff_len(reg_shadow[REG_RESET_LOW]) + eff_len(reg_shadow[REG_RESET_REC]),
                  RANDOM_LEVEL);
        add_ticks(1, 0);
        add_ticks(1, 1);
        drain();

        // short settings, every command kind
        set_all(1, 1, 3, 3, 1, 1, 2, 1);
        add_item(ACT_TICK, 8'h00, 1'b0);
        add_item(ACT_TICK, 8'hFF, 1'b1);
        add_item(ACT_RESET, 8'hFF, 1'b1);
        add_ticks(2, RANDOM_LEVEL);
        add_item(ACT_WRITE, 8'h00, 1'b0);
        add_ticks(1, 1);
        add_ticks(1, 0);
        add_item(ACT_READ, 8'h5A, 1'b1);
        add_ticks(1, 1);
        gen_reset(1);
        add_item(ACT_RESET, 8'h00, 1'b0);
        gen_reset(2);
        gen_write(8'hFF);
        gen_write(8'h00);
        drain();

        // zero-length settings
        set_all(0, 0, 0, 0, 0, 0, 0, 0);
        gen_mix(60);
        drain();

        repeat (2)
        begin
            set_random(30);
            gen_mix(100);
            drain();
        end

        set_random(12);
        gaps_on = 1'b0;
        gen_mix(100);

        spins = 0;
        while (responses_seen != items_queued && spins < 100000)
        begin
            @(posedge clk);
            spins++;
        end
        if (responses_seen != items_queued)
            flag_mismatch("result words still missing at end");
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("[one_wire_bus_master_unit] OK");
        else
            $display("[one_wire_bus_master_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[one_wire_bus_master_unit] ERROR");
        $finish;
    end

endmodule
